/* hw/rtl/tpdv_pkg.sv */
// Shared types and codes of the two-path distance-vector table.
// Used by the front, the command queue, the back and the top level.
`default_nettype none
package tpdv_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_ADVERT = 2'd3;

  localparam logic [2:0] REG_OWN_ADDRESS = 3'd0;

  localparam logic [5:0] METRIC_MAX = 6'd32;
  localparam logic [4:0] NO_HOP     = 5'd0;

  localparam int ENTRY_W = 23;  // present, metric2, hop2, metric1, hop1

  typedef struct packed {
    logic [1:0] op;
    logic       tsel;
    logic [4:0] tbl;
    logic [4:0] dest;
    logic [4:0] nh;
    logic [5:0] met;
  } cmd_t;

  typedef struct packed {
    logic [4:0] dest;
    logic [4:0] hop;
    logic [5:0] metric;
    logic       found;
    logic       swapped;
    logic       empty;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/two_path_distance_vector_table.sv */
// Two-path distance-vector routing table, top level: stream ports, APB
// register, front, command queue and back. Uses tpdv_pkg.
// Update and lookup read the one entry of their destination; remove and advertise
// walk all ADDRESSES entries, one table read per cycle while the output does not stall.
// After reset the back clears the table, one entry a cycle, all
// QOS_CLASSES*2*ADDRESSES entries (256 by default), with s_tready low.
`default_nettype none
module two_path_distance_vector_table #(
  parameter int ADDRESSES   = 32,
  parameter int QOS_CLASSES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // destination, next_hop, metric_in
  input  wire logic [4:0]  s_tuser,   // opcode, table_select, qos_class
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // dest_out, hop_out, metric_out
  output logic [2:0]       m_tuser,   // found, swapped, empty_res
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [4:0]     own_address;
  tpdv_pkg::cmd_t f_cmd;
  tpdv_pkg::cmd_t q_data;
  tpdv_pkg::res_t res;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           clearing;

  assign pready = 1'b1;
  assign prdata = (paddr == tpdv_pkg::REG_OWN_ADDRESS) ? {27'd0, own_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && paddr == tpdv_pkg::REG_OWN_ADDRESS) begin
      own_address <= pwdata[4:0];
    end
  end

  assign s_tready = !q_full && !clearing;

  tpdv_front #(.ADDRESSES(ADDRESSES), .QOS_CLASSES(QOS_CLASSES)) u_front (
    .opcode       (s_tuser[1:0]),
    .table_select (s_tuser[2]),
    .qos_class    (s_tuser[4:3]),
    .destination  (s_tdata[4:0]),
    .next_hop     (s_tdata[9:5]),
    .metric_in    (s_tdata[15:10]),
    .cmd          (f_cmd)
  );

  tpdv_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_data (f_cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tpdv_back #(.ADDRESSES(ADDRESSES), .QOS_CLASSES(QOS_CLASSES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .own_address (own_address),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out         (res)
  );

  assign m_tdata = {res.metric, res.hop, res.dest};
  assign m_tuser = {res.empty, res.swapped, res.found};
  assign m_tlast = res.last;

endmodule
`default_nettype wire

/* hw/rtl/tpdv_front.sv */
// Front: accepts input beats, saturates the metric, folds class and
// destination into range and forms a command. Uses tpdv_pkg.
`default_nettype none
module tpdv_front #(
  parameter int ADDRESSES   = 32,
  parameter int QOS_CLASSES = 4
) (
  input  wire logic [1:0] opcode,
  input  wire logic       table_select,
  input  wire logic [1:0] qos_class,
  input  wire logic [4:0] destination,
  input  wire logic [4:0] next_hop,
  input  wire logic [5:0] metric_in,
  output tpdv_pkg::cmd_t  cmd
);

  logic [4:0] dest_mod;
  logic [3:0] qos_mod;

  always_comb begin
    dest_mod = '0;
    for (int i = 0; i < 32; i++) begin
      if (destination == 5'(i)) dest_mod = 5'(i % ADDRESSES);
    end
    qos_mod = '0;
    for (int j = 0; j < 4; j++) begin
      if (qos_class == 2'(j)) qos_mod = 4'(j % QOS_CLASSES);
    end
  end

  always_comb begin
    cmd.op   = opcode;
    cmd.tsel = table_select;
    cmd.tbl  = {qos_mod, table_select};
    cmd.dest = dest_mod;
    cmd.nh   = next_hop;
    cmd.met  = (metric_in > tpdv_pkg::METRIC_MAX) ? tpdv_pkg::METRIC_MAX : metric_in;
  end

endmodule
`default_nettype wire

/* hw/rtl/tpdv_cmd_fifo.sv */
// Two-entry command queue between front and back.
// Uses tpdv_pkg::cmd_t.
`default_nettype none
module tpdv_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  tpdv_pkg::cmd_t     push_data,
  input  wire logic          pop,
  output tpdv_pkg::cmd_t     pop_data,
  output logic               full,
  output logic               empty
);

  tpdv_pkg::cmd_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

endmodule
`default_nettype wire

/* hw/rtl/tpdv_back.sv */
// Back: clears the table memory after reset, then runs commands from the
// queue as a walk over table entries with a one-entry hold for the last flag.
// Uses tpdv_pkg.
`default_nettype none
module tpdv_back #(
  parameter int ADDRESSES   = 32,
  parameter int QOS_CLASSES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [4:0] own_address,
  input  tpdv_pkg::cmd_t  q_data,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tpdv_pkg::res_t  out
);

  localparam int SLOTS = QOS_CLASSES * 2 * ADDRESSES;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(ADDRESSES);
  localparam int CW    = $clog2(ADDRESSES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [tpdv_pkg::ENTRY_W-1:0] RESET_ENTRY =
    {1'b0, tpdv_pkg::METRIC_MAX, tpdv_pkg::NO_HOP, tpdv_pkg::METRIC_MAX, tpdv_pkg::NO_HOP};

  logic [tpdv_pkg::ENTRY_W-1:0] mem [SLOTS];
  logic [tpdv_pkg::ENTRY_W-1:0] rdata;

  logic [1:0]     state;
  logic [1:0]     state_next;
  logic [SW-1:0]  clr;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  lim;
  tpdv_pkg::cmd_t cmd;
  logic           p_valid;
  logic [AW-1:0]  p_a;
  tpdv_pkg::res_t held;
  logic           held_valid;

  logic           rd_en;
  logic [SW-1:0]  rd_addr;
  logic [SW-1:0]  p_addr;
  logic           out_free;
  logic           produce;
  logic           wr_need;
  logic [tpdv_pkg::ENTRY_W-1:0] wr_entry;
  tpdv_pkg::res_t p_res;
  logic           stall;
  logic           consume;

  logic       pres;
  logic [4:0] h1, h2, uh1, uh2;
  logic [5:0] m1, m2, um1, um2;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || out_ready;
  assign rd_addr  = SW'(32'(cmd.tbl) * ADDRESSES + 32'(cnt[AW-1:0]));
  assign p_addr   = SW'(32'(cmd.tbl) * ADDRESSES + 32'(p_a));
  assign rd_en    = (state == ST_WALK) && (cnt != lim) && !stall;
  assign stall    = p_valid && produce && held_valid && !out_free;
  assign consume  = p_valid && !stall;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  assign pres = rdata[22];
  assign h1   = rdata[4:0];
  assign m1   = rdata[10:5];
  assign h2   = rdata[15:11];
  assign m2   = rdata[21:16];

  always_comb begin
    produce  = 1'b0;
    wr_need  = 1'b0;
    wr_entry = rdata;
    p_res    = '0;
    p_res.dest = 5'(p_a);
    uh1 = h1; um1 = m1; uh2 = h2; um2 = m2;
    unique case (cmd.op)
      tpdv_pkg::OP_UPDATE: begin
        if (h1 == cmd.nh) begin
          um1 = cmd.met;
        end else if (h2 == cmd.nh) begin
          um2 = cmd.met;
        end else if (m2 >= cmd.met) begin
          uh2 = cmd.nh;
          um2 = cmd.met;
        end
        produce = 1'b1;
        wr_need = 1'b1;
        if (um1 > um2) begin
          wr_entry      = {1'b1, um1, uh1, um2, uh2};
          p_res.swapped = 1'b1;
        end else begin
          wr_entry = {1'b1, um2, uh2, um1, uh1};
        end
      end
      tpdv_pkg::OP_LOOKUP: begin
        produce = 1'b1;
        if (pres && m1 < tpdv_pkg::METRIC_MAX && h1 != tpdv_pkg::NO_HOP) begin
          p_res.hop    = h1;
          p_res.metric = m1;
          p_res.found  = 1'b1;
        end else begin
          p_res.metric = tpdv_pkg::METRIC_MAX;
        end
      end
      tpdv_pkg::OP_REMOVE: begin
        if (pres && h2 == cmd.nh) begin
          wr_need  = 1'b1;
          wr_entry = {1'b1, tpdv_pkg::METRIC_MAX, tpdv_pkg::NO_HOP, m1, h1};
        end else if (pres && h1 == cmd.nh) begin
          wr_need  = 1'b1;
          produce  = 1'b1;
          wr_entry = {1'b1, tpdv_pkg::METRIC_MAX, tpdv_pkg::NO_HOP, m2, h2};
        end
      end
      default: begin
        if (pres && 8'(p_a) != 8'(cmd.nh)) begin
          produce = 1'b1;
          if (h1 == cmd.nh) begin
            p_res.metric = (h2 != tpdv_pkg::NO_HOP && m2 < tpdv_pkg::METRIC_MAX)
                           ? m2 : tpdv_pkg::METRIC_MAX;
          end else begin
            p_res.metric = (h1 != tpdv_pkg::NO_HOP && m1 < tpdv_pkg::METRIC_MAX)
                           ? m1 : tpdv_pkg::METRIC_MAX;
          end
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr == SW'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_next = ST_WALK;
      ST_WALK:  if (cnt == lim && (!p_valid || consume)) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      p_valid    <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      p_valid <= rd_en || stall;
      if (consume && produce && held_valid) begin
        out_valid <= 1'b1;
      end else if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE && !q_empty) begin
        held_valid <= (q_data.op == tpdv_pkg::OP_ADVERT) && q_data.tsel;
      end
      if (consume && produce) begin
        held_valid <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !q_empty) begin
      cmd <= q_data;
      if (q_data.op == tpdv_pkg::OP_UPDATE || q_data.op == tpdv_pkg::OP_LOOKUP) begin
        cnt <= CW'(q_data.dest);
        lim <= CW'(q_data.dest) + 1'b1;
      end else begin
        cnt <= '0;
        lim <= CW'(ADDRESSES);
      end
      held <= {own_address, 15'd0};
    end
    if (rd_en) begin
      cnt   <= cnt + 1'b1;
      p_a   <= cnt[AW-1:0];
      rdata <= mem[rd_addr];
    end
    if (consume && produce) begin
      held <= p_res;
      if (held_valid) out <= held;
    end
    if (state == ST_DONE && out_free) begin
      if (held_valid) begin
        out <= {held.dest, held.hop, held.metric, held.found, held.swapped, held.empty, 1'b1};
      end else begin
        out <= {5'd0, tpdv_pkg::NO_HOP, 6'd0, 1'b0, 1'b0, 1'b1, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr] <= RESET_ENTRY;
    end else if (consume && wr_need) begin
      mem[p_addr] <= wr_entry;
    end
  end

endmodule
`default_nettype wire
